>>> design/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// shared types and codes of the bitmap page frame allocator
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int CNT_W  = 13;
    localparam int PAGE_W = 12;

    // bitmap capacity in pages
    localparam int PAGE_CAP = 4096;

    // operation codes
    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_FREE    = 3'd1;
    localparam logic [2:0] OP_RSV     = 3'd2;
    localparam logic [2:0] OP_REL     = 3'd3;
    localparam logic [2:0] OP_RSV_ALL = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_IGN  = 2'd2;

    // decode outcome
    localparam logic [1:0] DK_REPLY = 2'd0;
    localparam logic [1:0] DK_SCAN  = 2'd1;
    localparam logic [1:0] DK_SWEEP = 2'd2;

    localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd4096;
    localparam logic [CNT_W-1:0] FREE_MAX    = 13'd4096;

    typedef struct packed {
        logic [2:0]        operation;
        logic [PAGE_W-1:0] start_page;
        logic [PAGE_W-1:0] end_page;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] page_index;
        logic [CNT_W-1:0]  free_pages;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic decode;
        logic scan_step;
        logic sweep;
        logic reply;
    } t_cmd;

    typedef struct packed {
        logic [1:0] dec_kind;
        logic       scan_stop;
        logic       sweep_last;
    } t_stat;

endpackage

>>> design/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// bpfa_ctrl
// sequencer of the allocator: fill, decode, word scan, drain, sweep and reply
// ----------------------------------------------------------------------------
module bpfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_free,
    input  bpfa_pkg::t_stat  i_stat,
    output bpfa_pkg::t_cmd   o_cmd,
    output logic             o_idle
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_SWEEP  = 3'd5;
    localparam logic [2:0] S_REPLY  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                unique case (i_stat.dec_kind)
                    bpfa_pkg::DK_SCAN:  n_state = S_SCAN;
                    bpfa_pkg::DK_SWEEP: n_state = S_SWEEP;
                    default:            n_state = S_REPLY;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_stop) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_REPLY;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) n_state = S_REPLY;
            end
            S_REPLY: begin
                o_cmd.reply = i_out_free;
                if (i_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

>>> design/bpfa_dp.sv
// ----------------------------------------------------------------------------
// bpfa_dp
// bitmap ram, word scan pipeline and free page counter
// ----------------------------------------------------------------------------
module bpfa_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bpfa_pkg::t_cmd                      i_cmd,
    input  bpfa_pkg::t_in_word                  i_req,
    input  logic [bpfa_pkg::CNT_W-1:0]          i_total,
    output bpfa_pkg::t_stat                     o_stat,
    output bpfa_pkg::t_out_word                 o_result
);

    localparam int WORDS = (bpfa_pkg::PAGE_CAP + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = AW + 5;
    localparam int LW    = $clog2(bpfa_pkg::PAGE_CAP + 1);
    localparam int CW    = (LW > bpfa_pkg::CNT_W) ? LW : bpfa_pkg::CNT_W;
    localparam logic [CW-1:0] MAX_C     = CW'(bpfa_pkg::PAGE_CAP);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
    localparam logic [31:0]   ONES      = '1;

    function automatic logic [5:0] f_popcount(input logic [31:0] v);
        logic [5:0] s;
        s = '0;
        for (int i = 0; i < 32; i++) begin
            s = s + 6'(v[i]);
        end
        return s;
    endfunction

    // bitmap store
    logic [31:0] r_mem [WORDS];
    logic [31:0] r_rdata;

    // request and scan registers
    bpfa_pkg::t_in_word          r_req;
    logic [AW-1:0]               r_waddr;
    logic [AW-1:0]               r_eaddr;
    logic [AW-1:0]               r_wlast;
    logic [AW-1:0]               r_lo_word;
    logic [4:0]                  r_lo_bit;
    logic [4:0]                  r_hi_bit;
    logic                        r_more;
    logic                        r_rvalid;
    logic [31:0]                 r_chg;
    logic                        r_chg_add;
    logic [1:0]                  r_status;
    logic [bpfa_pkg::PAGE_W-1:0] r_page;
    logic [bpfa_pkg::CNT_W-1:0]  r_count;

    // decode
    logic [CW-1:0] lim;
    logic [CW-1:0] lim_m1;
    logic [CW-1:0] start_ext;
    logic [CW-1:0] end_ext;
    logic [CW-1:0] span_hi;
    logic [PW-1:0] start_pw;
    logic [PW-1:0] span_pw;
    logic [1:0]    d_kind;
    logic [1:0]    d_status;
    logic [AW-1:0] d_first;
    logic [AW-1:0] d_last;
    logic [4:0]    d_lo_bit;
    logic [4:0]    d_hi_bit;

    assign lim       = (CW'(i_total) > MAX_C) ? MAX_C : CW'(i_total);
    assign lim_m1    = lim - CW'(1);
    assign start_ext = CW'(r_req.start_page);
    assign end_ext   = CW'(r_req.end_page);
    assign start_pw  = start_ext[PW-1:0];

    always_comb begin
        d_kind   = bpfa_pkg::DK_REPLY;
        d_status = bpfa_pkg::ST_IGN;
        d_first  = '0;
        d_last   = '0;
        d_lo_bit = '0;
        d_hi_bit = '0;
        span_hi  = (end_ext < lim) ? end_ext : lim_m1;
        span_pw  = span_hi[PW-1:0];
        unique case (r_req.operation)
            bpfa_pkg::OP_ALLOC: begin
                d_status = bpfa_pkg::ST_OOM;
                if (lim != '0) begin
                    span_pw  = lim_m1[PW-1:0];
                    d_kind   = bpfa_pkg::DK_SCAN;
                    d_last   = span_pw[PW-1:5];
                    d_hi_bit = span_pw[4:0];
                end
            end
            bpfa_pkg::OP_FREE: begin
                if (start_ext < lim) begin
                    d_kind   = bpfa_pkg::DK_SCAN;
                    d_first  = start_pw[PW-1:5];
                    d_last   = start_pw[PW-1:5];
                    d_lo_bit = start_pw[4:0];
                    d_hi_bit = start_pw[4:0];
                end
            end
            bpfa_pkg::OP_RSV, bpfa_pkg::OP_REL: begin
                if (r_req.start_page <= r_req.end_page) begin
                    d_status = bpfa_pkg::ST_DONE;
                    // a span wholly past the limit touches nothing
                    if (start_ext < lim) begin
                        d_kind   = bpfa_pkg::DK_SCAN;
                        d_first  = start_pw[PW-1:5];
                        d_lo_bit = start_pw[4:0];
                        d_last   = span_pw[PW-1:5];
                        d_hi_bit = span_pw[4:0];
                    end
                end
            end
            bpfa_pkg::OP_RSV_ALL: begin
                d_kind   = bpfa_pkg::DK_SWEEP;
                d_status = bpfa_pkg::ST_DONE;
            end
            default: begin
                d_status = bpfa_pkg::ST_IGN;
            end
        endcase
    end

    // word evaluation
    logic        eval;
    logic [4:0]  lo;
    logic [4:0]  hi;
    logic [31:0] mask;
    logic [31:0] cand;
    logic [31:0] iso;
    logic [4:0]  bitpos;
    logic [31:0] changed;
    logic        add_dir;
    logic        hit;
    logic [CW-1:0] page_ext;

    assign eval = i_cmd.scan_step && r_rvalid;
    assign lo   = (r_eaddr == r_lo_word) ? r_lo_bit : 5'd0;
    assign hi   = (r_eaddr == r_wlast) ? r_hi_bit : 5'd31;
    assign mask = (ONES << lo) & (ONES >> (5'd31 - hi));
    assign cand = ~r_rdata & mask;
    // lowest free page of the word
    assign iso  = cand & (~cand + 32'd1);

    always_comb begin
        bitpos = '0;
        for (int i = 0; i < 32; i++) begin
            if (iso[i]) bitpos = bitpos | 5'(i);
        end
    end

    always_comb begin
        add_dir = 1'b0;
        unique case (r_req.operation)
            bpfa_pkg::OP_ALLOC: changed = iso;
            bpfa_pkg::OP_FREE: begin
                changed = r_rdata & mask;
                add_dir = 1'b1;
            end
            bpfa_pkg::OP_RSV:   changed = mask & ~r_rdata;
            bpfa_pkg::OP_REL: begin
                changed = mask & r_rdata;
                add_dir = 1'b1;
            end
            default:            changed = '0;
        endcase
    end

    assign hit      = |changed;
    assign page_ext = CW'({r_eaddr, bitpos});

    // memory ports
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;
    logic          mem_re;

    assign mem_we = i_cmd.sweep || eval;
    assign mem_wa = i_cmd.sweep ? r_waddr : r_eaddr;
    assign mem_wd = i_cmd.sweep ? ONES : (r_rdata ^ changed);
    assign mem_re = i_cmd.scan_step && r_more;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= r_mem[r_waddr];
    end

    // scan and sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waddr   <= '0;
            r_more    <= 1'b0;
            r_rvalid  <= 1'b0;
            r_chg     <= '0;
            r_chg_add <= 1'b0;
        end else begin
            r_chg     <= eval ? changed : 32'd0;
            r_chg_add <= add_dir;
            if (i_cmd.decode) begin
                r_waddr  <= (d_kind == bpfa_pkg::DK_SWEEP) ? '0 : d_first;
                r_more   <= 1'b1;
                r_rvalid <= 1'b0;
            end else if (i_cmd.sweep) begin
                r_waddr <= (r_waddr == LAST_WORD) ? '0 : r_waddr + AW'(1);
            end else if (i_cmd.scan_step) begin
                r_rvalid <= r_more;
                if (r_more) begin
                    r_waddr <= r_waddr + AW'(1);
                    r_more  <= (r_waddr != r_wlast);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (mem_re) r_eaddr <= r_waddr;
        if (i_cmd.decode) begin
            r_wlast   <= d_last;
            r_lo_word <= d_first;
            r_lo_bit  <= d_lo_bit;
            r_hi_bit  <= d_hi_bit;
            r_status  <= d_status;
            r_page    <= '0;
        end else if (eval && hit) begin
            r_status <= bpfa_pkg::ST_DONE;
            if (r_req.operation == bpfa_pkg::OP_ALLOC) begin
                r_page <= page_ext[bpfa_pkg::PAGE_W-1:0];
            end
        end
    end

    // free page count, one word of changes behind the scan
    logic [5:0]                 pop;
    logic [bpfa_pkg::CNT_W-1:0] pop_ext;

    assign pop     = f_popcount(r_chg);
    assign pop_ext = bpfa_pkg::CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.decode && r_req.operation == bpfa_pkg::OP_RSV_ALL) begin
            r_count <= '0;
        end else if (r_chg_add) begin
            r_count <= r_count + pop_ext;
        end else begin
            r_count <= (pop_ext > r_count) ? '0 : r_count - pop_ext;
        end
    end

    assign o_stat.dec_kind   = d_kind;
    assign o_stat.scan_stop  = r_rvalid &&
                               ((r_eaddr == r_wlast) ||
                                (r_req.operation == bpfa_pkg::OP_ALLOC && hit));
    assign o_stat.sweep_last = (r_waddr == LAST_WORD);

    assign o_result.status     = r_status;
    assign o_result.page_index = r_page;
    assign o_result.free_pages = r_count;

endmodule

>>> design/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// first-fit page frame allocator over a one-bit-per-page used bitmap
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  word
//  -------  ---------  -------------------------  --------------------------
//  in       input      i_in_valid / o_in_stall    operation, start/end page
//  out      output     o_out_valid / i_out_stall  status, page index, count
//  cfg      input      i_cfg_we                   total_pages, 13 bits
//
//  alloc, free and range words scan up to PAGE_CAP/32 bitmap words (128 with
//    4096 pages) between accept and result; the bitmap ram reads one
//    32-bit word and writes one per cycle
//  reserve-all writes all ones to every ram row, one ram row written per cycle
//  rejected words and ranges past the limit answer without a scan
//  reset: a fill pass writes all ones to the bitmap, in stalls
//  meanwhile; cfg writes are taken at any time
//  one word is worked on at a time; a finished result sits in the output
//  register, so the next word is taken while the result waits on i_out_stall
//
module bitmap_page_frame_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bpfa_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bpfa_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_we,
    input  logic [bpfa_pkg::CNT_W-1:0]        i_cfg_wdata
);

    bpfa_pkg::t_cmd      cmd;
    bpfa_pkg::t_stat     stat;
    bpfa_pkg::t_out_word result;
    logic                idle;
    logic                out_free;

    logic [bpfa_pkg::CNT_W-1:0] r_total;
    logic                       r_out_valid;
    bpfa_pkg::t_out_word        r_out_word;

    // page limit register, kept as written; clamping is done at decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= bpfa_pkg::TOTAL_RESET;
        end else if (i_cfg_we) begin
            r_total <= i_cfg_wdata;
        end
    end

    // output register frees the sequencer from the downstream stall
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.reply) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.reply) r_out_word <= result;
    end

    // sequencer
    bpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    // bitmap, scan pipeline and counter
    bpfa_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_in_word),
        .i_total  (r_total),
        .o_stat   (stat),
        .o_result (result)
    );

    assign o_in_stall  = !idle;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a taken word blocks the input until its result is out
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in work");

    // a result never overwrites one that is still stalled
    a_reply_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.reply |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten under stall");

    // out of memory carries no page
    a_oom_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == bpfa_pkg::ST_OOM)
            |-> (o_out_word.page_index == '0))
        else $error("out of memory result with a page index");

    // only pages addressable by the 12-bit fields can ever be freed
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.free_pages <= bpfa_pkg::FREE_MAX))
        else $error("free page count beyond range");

endmodule
